// File: hdl/mmn_pkg.sv
// mmn_pkg: shared constants and controller/datapath interface types
// for the min-max normalize block; no dependencies
package mmn_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int OUT_BITS        = 16;
  localparam int RCP_BITS        = 32;
  localparam int DIV_CNT_BITS    = $clog2(RCP_BITS);
  localparam int FRAC_SHIFT      = 16;
  localparam logic [OUT_BITS-1:0] Q_ONE = 16'h8000;

  localparam int TUSER_CMD   = 0;
  localparam int TUSER_START = 1;

  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_APPLY   = 1'b1;

  typedef struct packed {
    logic meas;
    logic restart;
    logic load_x;
    logic div_init;
    logic div_step;
    logic mul;
    logic sat;
  } mmn_cmd_t;

  typedef struct packed {
    logic rcp_ready;
    logic span_flat;
    logic div_last;
  } mmn_sts_t;

endpackage

// File: hdl/mmn_ctrl.sv
// mmn_ctrl: sequencing state machine for the min-max normalize block
// depends on mmn_pkg
module mmn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic              in_start,
  output logic              out_valid,
  input  logic              out_ready,
  output mmn_pkg::mmn_cmd_t cmd,
  input  mmn_pkg::mmn_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_SAT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_full;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_command == mmn_pkg::CMD_MEASURE) begin
            cmd.meas    = 1'b1;
            cmd.restart = in_start;
          end else begin
            cmd.load_x = 1'b1;
            if (in_start || !sts.rcp_ready) begin
              cmd.div_init = 1'b1;
              state_next   = sts.span_flat ? S_MUL : S_DIV;
            end else begin
              state_next = S_MUL;
            end
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SAT;
      end
      S_SAT: begin
        // output register free or draining this cycle
        if (!out_full || out_ready) begin
          cmd.sat    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.sat) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/mmn_datapath.sv
// mmn_datapath: running min/max, serial reciprocal divider, multiply and saturate
// depends on mmn_pkg
module mmn_datapath #(
  parameter int SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mmn_pkg::mmn_cmd_t             cmd,
  output mmn_pkg::mmn_sts_t             sts,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic [mmn_pkg::OUT_BITS-1:0]  normalized,
  output logic                          flat_range
);

  localparam int SB        = SAMPLE_BITS;
  localparam int PROD_BITS = SB + mmn_pkg::RCP_BITS;
  localparam int SHR_BITS  = PROD_BITS - mmn_pkg::FRAC_SHIFT;

  localparam logic signed [SB-1:0] MOST_POS = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};
  localparam logic [mmn_pkg::DIV_CNT_BITS-1:0] CNT_LAST = '1;

  logic signed [SB-1:0]               run_min;
  logic signed [SB-1:0]               run_max;
  logic                               rcp_ready;
  logic                               range_flat;
  logic signed [SB-1:0]               x;
  logic [mmn_pkg::RCP_BITS-1:0]       recip;
  logic [SB-1:0]                      rem;
  logic [mmn_pkg::DIV_CNT_BITS-1:0]   cnt;
  logic [PROD_BITS-1:0]               prod;

  logic signed [SB-1:0] base_min;
  logic signed [SB-1:0] base_max;
  logic signed [SB:0]   span_full;
  logic [SB-1:0]        span;
  logic [SB:0]          rem_sh;
  logic                 rem_ge;
  logic signed [SB:0]   diff;
  logic [SHR_BITS-1:0]  shr;

  assign base_min  = cmd.restart ? MOST_POS : run_min;
  assign base_max  = cmd.restart ? MOST_NEG : run_max;
  assign span_full = {run_max[SB-1], run_max} - {run_min[SB-1], run_min};
  assign span      = span_full[SB-1:0];
  assign rem_sh    = {rem, (cnt == '0)};
  assign rem_ge    = rem_sh >= {1'b0, span};
  assign diff      = {x[SB-1], x} - {run_min[SB-1], run_min};
  assign shr       = prod[PROD_BITS-1:mmn_pkg::FRAC_SHIFT];

  assign sts.rcp_ready = rcp_ready;
  assign sts.span_flat = (run_max <= run_min);
  assign sts.div_last  = (cnt == CNT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min    <= MOST_POS;
      run_max    <= MOST_NEG;
      rcp_ready  <= 1'b0;
      range_flat <= 1'b0;
      cnt        <= '0;
    end else begin
      if (cmd.meas) begin
        run_min   <= (sample < base_min) ? sample : base_min;
        run_max   <= (sample > base_max) ? sample : base_max;
        rcp_ready <= 1'b0;
      end
      if (cmd.div_init) begin
        cnt <= '0;
        if (sts.span_flat) begin
          range_flat <= 1'b1;
          rcp_ready  <= 1'b1;
        end
      end
      if (cmd.div_step) begin
        cnt <= cnt + 1'b1;
        if (sts.div_last) begin
          range_flat <= 1'b0;
          rcp_ready  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x <= sample;
    end
    if (cmd.div_init) begin
      rem   <= '0;
      recip <= '0;
    end
    if (cmd.div_step) begin
      rem   <= rem_ge ? rem_sh[SB-1:0] - span : rem_sh[SB-1:0];
      recip <= {recip[mmn_pkg::RCP_BITS-2:0], rem_ge};
    end
    if (cmd.mul) begin
      if (!diff[SB] && (diff != '0)) begin
        prod <= PROD_BITS'(diff[SB-1:0]) * PROD_BITS'(recip);
      end else begin
        prod <= '0;
      end
    end
    if (cmd.sat) begin
      flat_range <= range_flat;
      if (range_flat) begin
        normalized <= '0;
      end else if (shr > SHR_BITS'(mmn_pkg::Q_ONE)) begin
        normalized <= mmn_pkg::Q_ONE;
      end else begin
        normalized <= shr[mmn_pkg::OUT_BITS-1:0];
      end
    end
  end

  a_div_sets_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step && sts.div_last |=> rcp_ready && !range_flat)
    else $error("reciprocal not ready after last division step");

  a_meas_clears_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.meas |=> !rcp_ready)
    else $error("measure transaction left reciprocal marked ready");

  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.sat && range_flat |=> flat_range && (normalized == '0))
    else $error("flat range result not zero");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.sat |=> normalized <= mmn_pkg::Q_ONE)
    else $error("normalized value above one");

endmodule

// File: hdl/min_max_normalize.sv
// min_max_normalize: top level of the two-pass min-max contrast stretch
// depends on mmn_pkg, mmn_ctrl, mmn_datapath
//
//  channel  dir  tdata                         tuser
//  s_axis   in   sample                        command, frame_start
//  m_axis   out  normalized                    flat_range
//
// measure transaction: accepted without leaving idle, no result
// apply transaction: multiply then saturate step; result valid from the output
//   register, when the next transaction can also be taken; a reciprocal recompute
//   first runs the serial divider (one quotient bit per cycle), skipped for a flat range
// the result waits in an output register; a following apply stalls in its
//   saturate step until that register drains
// rst is synchronous and returns min/max to their extreme values
module min_max_normalize #(
  parameter int SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,  // sample
  input  logic [1:0]                          s_axis_tuser,  // command, frame_start
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mmn_pkg::OUT_BITS-1:0]        m_axis_tdata,  // normalized
  output logic [0:0]                          m_axis_tuser   // flat_range
);

  mmn_pkg::mmn_cmd_t cmd;
  mmn_pkg::mmn_sts_t sts;
  logic              flat_range;

  assign m_axis_tuser[0] = flat_range;

  mmn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_command (s_axis_tuser[mmn_pkg::TUSER_CMD]),
    .in_start   (s_axis_tuser[mmn_pkg::TUSER_START]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mmn_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .sample     ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .normalized (m_axis_tdata),
    .flat_range (flat_range)
  );

endmodule

// File: test/min_max_normalize_test.sv
// min_max_normalize_test: self-checking testbench for the two-pass min-max stretch
// drives measure and apply transactions, predicts each stretched result and compares
// depends on mmn_pkg and min_max_normalize
module min_max_normalize_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [mmn_pkg::OUT_BITS-1:0] normalized;
    logic                         flat_range;
  } stretch_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [15:0]                  s_axis_tdata = '0;
  logic [1:0]                   s_axis_tuser = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [mmn_pkg::OUT_BITS-1:0] m_axis_tdata;
  logic [0:0]                   m_axis_tuser;

  // predictor state
  logic signed [15:0] cur_min;
  logic signed [15:0] cur_max;
  logic [31:0]        scale;
  logic               scale_valid;
  logic               span_flat;
  stretch_t           stretch_due[$];
  stretch_t           want;
  int                 mismatches = 0;

  // sender and receiver idling
  bit gaps_on = 1'b0;
  int burst_left = 0;
  int stall_mode = 0;
  int rx_run_left = 0;
  bit rx_state = 1'b1;
  int hold_len = 0;
  bit hold_go = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  min_max_normalize #(.SAMPLE_BITS(16)) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #10 clk = ~clk;

  task automatic predict_stretch(input logic cmd, input logic start,
                                 input logic signed [15:0] x);
    stretch_t         r;
    int               span;
    int               diff;
    longint unsigned  prod;
    if (cmd == mmn_pkg::CMD_MEASURE) begin
      if (start) begin
        cur_min = 16'sh7fff;
        cur_max = -16'sh8000;
      end
      if (x < cur_min) cur_min = x;
      if (x > cur_max) cur_max = x;
      scale_valid = 1'b0;
      return;
    end
    if (start || !scale_valid) begin
      if (cur_max <= cur_min) begin
        span_flat = 1'b1;
        scale = '0;
      end else begin
        span = int'(cur_max) - int'(cur_min);
        span_flat = 1'b0;
        scale = 32'((64'd1 << 31) / 64'(span));
      end
      scale_valid = 1'b1;
    end
    if (span_flat) begin
      r.normalized = '0;
      r.flat_range = 1'b1;
    end else begin
      diff = int'(x) - int'(cur_min);
      prod = 0;
      if (diff > 0) begin
        prod = (longint'(diff) * longint'(scale)) >> mmn_pkg::FRAC_SHIFT;
        if (prod > mmn_pkg::Q_ONE) prod = mmn_pkg::Q_ONE;
      end
      r.normalized = prod[mmn_pkg::OUT_BITS-1:0];
      r.flat_range = 1'b0;
    end
    stretch_due.push_back(r);
  endtask

  task automatic send_sample(input logic cmd, input logic start, input logic signed [15:0] x);
    logic [1:0] tu;
    tu = '0;
    tu[mmn_pkg::TUSER_CMD] = cmd;
    tu[mmn_pkg::TUSER_START] = start;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= x;
    s_axis_tuser <= tu;
    do @(posedge clk); while (!s_axis_tready);
    predict_stretch(cmd, start, x);
    burst_left--;
    if (gaps_on && burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  function automatic logic signed [15:0] pick_between(int lo, int hi);
    return 16'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // receiver: long hold-off on request, otherwise its own ready pattern
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_mode == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (rx_run_left <= 0) begin
        rx_state = !rx_state;
        rx_run_left = rx_state ? $urandom_range(1, 12) : $urandom_range(1, 6);
      end
      rx_run_left--;
      m_axis_tready <= rx_state;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (stretch_due.size() == 0) begin
        $error("normalized: expected no transaction, got %0d", m_axis_tdata);
        mismatches++;
      end else begin
        want = stretch_due.pop_front();
        if (m_axis_tdata !== want.normalized) begin
          $error("normalized: expected %0d, got %0d", want.normalized, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.flat_range) begin
          $error("flat_range: expected %0d, got %0d", want.flat_range, m_axis_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  task automatic test_empty_measure();
    send_sample(mmn_pkg::CMD_APPLY, 1'b1, 16'sd0);
    send_sample(mmn_pkg::CMD_APPLY, 1'b0, 16'sh7fff);
  endtask

  task automatic test_flat_range();
    send_sample(mmn_pkg::CMD_MEASURE, 1'b1, 16'sd100);
    send_sample(mmn_pkg::CMD_MEASURE, 1'b0, 16'sd100);
    send_sample(mmn_pkg::CMD_APPLY, 1'b1, 16'sd100);
    send_sample(mmn_pkg::CMD_APPLY, 1'b0, 16'sd0);
  endtask

  task automatic test_full_span();
    send_sample(mmn_pkg::CMD_MEASURE, 1'b1, -16'sh8000);
    send_sample(mmn_pkg::CMD_MEASURE, 1'b0, 16'sh7fff);
    send_sample(mmn_pkg::CMD_APPLY, 1'b1, -16'sh8000);
    send_sample(mmn_pkg::CMD_APPLY, 1'b0, 16'sh7fff);
    send_sample(mmn_pkg::CMD_APPLY, 1'b0, 16'sd0);
  endtask

  task automatic test_unit_span();
    send_sample(mmn_pkg::CMD_MEASURE, 1'b1, 16'sd5);
    send_sample(mmn_pkg::CMD_MEASURE, 1'b0, 16'sd6);
    // apply without frame start still recomputes the reciprocal
    send_sample(mmn_pkg::CMD_APPLY, 1'b0, 16'sd5);
    send_sample(mmn_pkg::CMD_APPLY, 1'b0, 16'sd6);
    send_sample(mmn_pkg::CMD_APPLY, 1'b0, 16'sd7);
    send_sample(mmn_pkg::CMD_APPLY, 1'b0, 16'sd4);
  endtask

  task automatic test_measure_after_apply();
    send_sample(mmn_pkg::CMD_MEASURE, 1'b0, 16'sd20);
    send_sample(mmn_pkg::CMD_APPLY, 1'b0, 16'sd20);
    send_sample(mmn_pkg::CMD_APPLY, 1'b0, 16'sd12);
  endtask

  task automatic test_input_stall();
    int k;
    gaps_on = 1'b0;
    hold_len = 300;
    hold_go = !hold_go;
    send_sample(mmn_pkg::CMD_MEASURE, 1'b1, -16'sd1000);
    send_sample(mmn_pkg::CMD_MEASURE, 1'b0, 16'sd1000);
    for (k = 0; k < 10; k++) begin
      send_sample(mmn_pkg::CMD_APPLY, k == 0, pick_between(-1200, 1200));
    end
  endtask

  task automatic test_random_frames(input int n_items);
    int sent, w, lo, hi, n_meas, n_app, n_noise, kind, k;
    logic signed [15:0] x;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 4))
        0: w = 0;
        1: w = 1;
        2: w = $urandom_range(2, 64);
        3: w = $urandom_range(65, 65535);
        default: w = 65535;
      endcase
      lo = -32768 + int'($urandom_range(0, 65535 - w));
      hi = lo + w;
      if (kind < 8) begin
        n_meas = $urandom_range(1, 10);
        for (k = 0; k < n_meas; k++) begin
          if (k == 0) x = ($urandom_range(0, 1) != 0) ? 16'(lo) : 16'(hi);
          else if (k == n_meas - 1) x = 16'(lo + hi - int'(cur_min) - int'(cur_max) > 0 ? hi : lo);
          else x = pick_between(lo, hi);
          send_sample(mmn_pkg::CMD_MEASURE, k == 0, x);
        end
        n_app = $urandom_range(1, 16);
        for (k = 0; k < n_app; k++) begin
          if ($urandom_range(0, 7) == 0) x = 16'($urandom_range(0, 65535));
          else x = pick_between(lo, hi);
          // one frame in eight relies on the recompute without frame start
          send_sample(mmn_pkg::CMD_APPLY, k == 0 && kind != 7, x);
        end
        sent += n_meas + n_app;
      end else begin
        n_noise = $urandom_range(1, 8);
        for (k = 0; k < n_noise; k++) begin
          send_sample(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                      16'($urandom_range(0, 65535)));
        end
        sent += n_noise;
      end
    end
  endtask

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int n;
    cur_min = 16'sh7fff;
    cur_max = -16'sh8000;
    scale = '0;
    scale_valid = 1'b0;
    span_flat = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_measure();
    test_flat_range();
    test_full_span();
    test_unit_span();
    test_measure_after_apply();
    test_input_stall();
    stall_mode = 0;
    gaps_on = 1'b0;
    test_random_frames(225);
    gaps_on = 1'b1;
    test_random_frames(225);
    gaps_on = 1'b0;
    stall_mode = 1;
    test_random_frames(225);
    gaps_on = 1'b1;
    test_random_frames(225);
    s_axis_tvalid <= 1'b0;
    n = 0;
    while (stretch_due.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (60) @(posedge clk);
    if (stretch_due.size() != 0) begin
      $error("normalized: %0d expected transactions never arrived", stretch_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mmn_pkg.sv
hdl/mmn_ctrl.sv
hdl/mmn_datapath.sv
hdl/min_max_normalize.sv
test/min_max_normalize_test.sv
